[design/lesf_pkg.sv]
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types and constants of the Laplace edge-strength filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lesf_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = COL_W + 1;
  localparam int DEPTH     = 2 * MAX_WIDTH;

  // field widths
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int KEPT_W     = CH_W - 1;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int KEEP_W     = 3;
  localparam int POS_X_W    = 10;
  localparam int POS_Y_W    = 16;
  localparam int STRENGTH_W = 11;

  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 11'd1524;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [KEEP_W-1:0]   KEEP_RST   = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KEEP_BITS    = 2'd2
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // which of the four neighbours lie inside the image
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_en_t;

endpackage

`default_nettype wire

[design/lesf_if.sv]
// ----------------------------------------------------------------------------
// lesf_if
// Valid/ready channels: RGB pixel stream in, filter results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lesf_pix_if;
  import lesf_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lesf_res_if;
  import lesf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [POS_X_W-1:0]    pos_x;
  logic [POS_Y_W-1:0]    pos_y;
  logic [STRENGTH_W-1:0] strength;
  logic                  run_last;

  modport source (output valid, output pos_x, output pos_y, output strength,
                  output run_last, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input strength,
                  input run_last, output ready);
endinterface

`default_nettype wire

[design/lesf_strength.sv]
// ----------------------------------------------------------------------------
// lesf_strength
// Four-neighbour Laplace magnitude of one pixel, summed over R, G and B.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_strength (
  input  logic [lesf_pkg::KEEP_W-1:0]     keep_i,
  input  lesf_pkg::pix_t                  centre_i,
  input  lesf_pkg::pix_t                  up_i,
  input  lesf_pkg::pix_t                  down_i,
  input  lesf_pkg::pix_t                  left_i,
  input  lesf_pkg::pix_t                  right_i,
  input  lesf_pkg::nb_en_t                nb_en_i,
  output logic [lesf_pkg::STRENGTH_W-1:0] strength_o
);
  import lesf_pkg::*;

  logic [3:0]        shift;
  logic [2:0]        n_nb;
  logic [KEPT_W-1:0] ctr  [3];
  logic [KEPT_W-1:0] up   [3];
  logic [KEPT_W-1:0] dn   [3];
  logic [KEPT_W-1:0] lf   [3];
  logic [KEPT_W-1:0] rt   [3];
  logic [8:0]        nsum [3];
  logic [9:0]        prod [3];
  logic [9:0]        mag  [3];

  // keep_bits of 0 shifts by 8, which clears the channel
  assign shift = 4'd8 - 4'(keep_i);
  assign n_nb  = 3'(nb_en_i.up) + 3'(nb_en_i.down) + 3'(nb_en_i.left) + 3'(nb_en_i.right);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k]  = KEPT_W'(centre_i[CH_W*k +: CH_W] >> shift);
      up[k]   = nb_en_i.up    ? KEPT_W'(up_i[CH_W*k +: CH_W] >> shift)    : '0;
      dn[k]   = nb_en_i.down  ? KEPT_W'(down_i[CH_W*k +: CH_W] >> shift)  : '0;
      lf[k]   = nb_en_i.left  ? KEPT_W'(left_i[CH_W*k +: CH_W] >> shift)  : '0;
      rt[k]   = nb_en_i.right ? KEPT_W'(right_i[CH_W*k +: CH_W] >> shift) : '0;
      nsum[k] = 9'(up[k]) + 9'(dn[k]) + 9'(lf[k]) + 9'(rt[k]);
      prod[k] = 10'({3'b0, ctr[k]} * {7'b0, n_nb});
      if (prod[k] >= 10'(nsum[k])) begin
        mag[k] = prod[k] - 10'(nsum[k]);
      end else begin
        mag[k] = 10'(nsum[k]) - prod[k];
      end
    end
  end

  assign strength_o = STRENGTH_W'(mag[0]) + STRENGTH_W'(mag[1]) + STRENGTH_W'(mag[2]);

endmodule

`default_nettype wire

[design/laplace_edge_strength_filter.sv]
// ----------------------------------------------------------------------------
// laplace_edge_strength_filter
// Raster-order RGB in, four-neighbour Laplace edge strength per pixel out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the result stage holds it back. A pixel's
// result needs the pixel below it, so results trail the input by one row; each
// result is registered in the result stage and then in the output register. In
// every row but the last a pixel gives at most one result. A pixel of the last
// row gives at most two (three at the end of the row), and since the output
// register takes one result per cycle when res_o.ready allows, the input is held
// until they have left. Two image rows sit in a 2048 x 24 line store with one
// write and two read ports, read-first and registered: per pixel it reads the row
// above one column ahead and the row two above at the same column, while the pixel
// is written back. The store needs no clearing pass; only entries already written are used.
// Writing image_width or image_height restarts the frame at its first pixel.
`default_nettype none

module laplace_edge_strength_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lesf_pix_if.sink                        pix_i,
  lesf_res_if.source                      res_o
);
  import lesf_pkg::*;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_gt0;
    logic c_gt1;
    logic c_lt_last;
  } geo_t;

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [KEEP_W-1:0]   keep_q;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  // raster position
  logic [COL_W-1:0]    col_q, col_d, col_cur;
  logic [HEIGHT_W-1:0] row_q, row_d, row_cur;
  logic [COL_W:0]      col_nx;
  logic [HEIGHT_W:0]   row_nx;
  logic                last_col, last_row;

  // line store
  pix_t              line_mem [DEPTH];
  pix_t              pix_in;
  logic [ADDR_W-1:0] wr_addr, rd_ahead_addr;
  pix_t              rd_ahead_q, rd_above2_q;
  logic              fwd_q, fwd_d;

  // pixel window: p0 current, p1/p2 to its left; u0 above, u1 above-left
  pix_t p0_q, p1_q, p2_q, u0_q, u1_q;

  // result stage
  logic                s_valid_q;
  logic [2:0]          s_mask_q, mask_new, sel, mask_rest;
  logic [COL_W-1:0]    s_col_q;
  logic [HEIGHT_W-1:0] s_row_q;
  geo_t                s_geo_q;
  logic                last_res, adv, accept;

  // operands of the selected result
  pix_t                  op_ctr, op_up, op_dn, op_lf, op_rt;
  nb_en_t                op_en;
  logic [POS_X_W-1:0]    op_x;
  logic [POS_Y_W-1:0]    op_y;
  logic [STRENGTH_W-1:0] strength;

  // output register
  logic                  out_valid_q;
  logic [POS_X_W-1:0]    pos_x_q;
  logic [POS_Y_W-1:0]    pos_y_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic                  run_last_q;

  // --------------------------------------------------------------------------
  // geometry
  // --------------------------------------------------------------------------
  always_comb begin
    if (width_q == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
  end

  assign eff_h    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  assign col_cur  = ({1'b0, col_q} >= (COL_W+1)'(eff_w)) ? '0 : col_q;
  assign row_cur  = (row_q >= eff_h) ? '0 : row_q;
  assign col_nx   = {1'b0, col_cur} + (COL_W+1)'(1);
  assign row_nx   = {1'b0, row_cur} + (HEIGHT_W+1)'(1);
  assign last_col = col_nx >= (COL_W+1)'(eff_w);
  assign last_row = row_nx >= {1'b0, eff_h};

  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_nx[HEIGHT_W-1:0];
    end else begin
      col_d = col_nx[COL_W-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      keep_q   <= KEEP_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[WIDTH_W-1:0];
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[HEIGHT_W-1:0];
          col_q    <= '0;
          row_q    <= '0;
        end
        REG_KEEP_BITS: keep_q <= cfg_data_i[KEEP_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // line store: row y lives in half y[0]
  // --------------------------------------------------------------------------
  assign pix_in  = {pix_i.blue, pix_i.green, pix_i.red};
  assign wr_addr = {row_cur[0], col_cur};

  // Look one column ahead in the row above; at the row end fetch column 0 of
  // this row instead, which the next row needs first.
  assign rd_ahead_addr = last_col ? {row_cur[0], COL_W'(0)}
                                  : {~row_cur[0], col_nx[COL_W-1:0]};
  // one-pixel-wide image: that column 0 is the pixel being written now
  assign fwd_d = last_col && (col_cur == '0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[wr_addr] <= pix_in;
      rd_ahead_q        <= line_mem[rd_ahead_addr];
      rd_above2_q       <= line_mem[wr_addr];
      p0_q              <= pix_in;
      p1_q              <= p0_q;
      p2_q              <= p1_q;
      u0_q              <= fwd_q ? p0_q : rd_ahead_q;
      u1_q              <= u0_q;
    end
  end

  // --------------------------------------------------------------------------
  // result stage: up to three results per pixel, one per cycle while the output register can take it
  //   bit 0: (c, r-1)  bit 1: (c-1, r) in the last row  bit 2: (c, r) at the end of the last row
  // --------------------------------------------------------------------------
  assign mask_new = {last_row && last_col, last_row && (col_cur != '0), row_cur != '0};

  assign sel[0]    = s_mask_q[0];
  assign sel[1]    = s_mask_q[1] & ~s_mask_q[0];
  assign sel[2]    = s_mask_q[2] & ~s_mask_q[1] & ~s_mask_q[0];
  assign mask_rest = s_mask_q & ~sel;
  assign last_res  = (mask_rest == '0);

  assign adv         = s_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s_valid_q || (adv && last_res);
  assign accept      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_mask_q  <= '0;
      fwd_q     <= 1'b0;
    end else if (accept) begin
      s_valid_q <= |mask_new;
      s_mask_q  <= mask_new;
      fwd_q     <= fwd_d;
    end else if (adv) begin
      s_valid_q <= !last_res;
      s_mask_q  <= mask_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_col_q           <= col_cur;
      s_row_q           <= row_cur;
      s_geo_q.r_ge1     <= row_cur != '0;
      s_geo_q.r_ge2     <= row_cur > HEIGHT_W'(1);
      s_geo_q.c_gt0     <= col_cur != '0;
      s_geo_q.c_gt1     <= col_cur > COL_W'(1);
      s_geo_q.c_lt_last <= !last_col;
    end
  end

  always_comb begin
    op_dn = '0;
    op_rt = '0;
    if (sel[0]) begin
      op_ctr = u0_q;
      op_up  = rd_above2_q;
      op_dn  = p0_q;
      op_lf  = u1_q;
      op_rt  = rd_ahead_q;
      op_en  = '{up: s_geo_q.r_ge2, down: 1'b1, left: s_geo_q.c_gt0,
                 right: s_geo_q.c_lt_last};
      op_x   = s_col_q;
      op_y   = s_row_q - POS_Y_W'(1);
    end else if (sel[1]) begin
      op_ctr = p1_q;
      op_up  = u1_q;
      op_lf  = p2_q;
      op_rt  = p0_q;
      op_en  = '{up: s_geo_q.r_ge1, down: 1'b0, left: s_geo_q.c_gt1, right: 1'b1};
      op_x   = s_col_q - POS_X_W'(1);
      op_y   = s_row_q;
    end else begin
      op_ctr = p0_q;
      op_up  = u0_q;
      op_lf  = p1_q;
      op_en  = '{up: s_geo_q.r_ge1, down: 1'b0, left: s_geo_q.c_gt0, right: 1'b0};
      op_x   = s_col_q;
      op_y   = s_row_q;
    end
  end

  lesf_strength u_strength (
    .keep_i     (keep_q),
    .centre_i   (op_ctr),
    .up_i       (op_up),
    .down_i     (op_dn),
    .left_i     (op_lf),
    .right_i    (op_rt),
    .nb_en_i    (op_en),
    .strength_o (strength)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_q    <= op_x;
      pos_y_q    <= op_y;
      strength_q <= strength;
      run_last_q <= last_res;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.pos_x    = pos_x_q;
  assign res_o.pos_y    = pos_y_q;
  assign res_o.strength = strength_q;
  assign res_o.run_last = run_last_q;

endmodule

`default_nettype wire

[design/lesf_checker.sv]
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level checks of the Laplace edge-strength filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            pix_valid_i,
  input logic                            pix_ready_i,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic [lesf_pkg::POS_X_W-1:0]    pos_x_i,
  input logic [lesf_pkg::POS_Y_W-1:0]    pos_y_i,
  input logic [lesf_pkg::STRENGTH_W-1:0] strength_i,
  input logic                            run_last_i
);
  import lesf_pkg::*;

  // a stalled result holds still
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(pos_x_i) && $stable(pos_y_i)
      && $stable(strength_i) && $stable(run_last_i))
    else $error("result changed while stalled");

  // a result appears only as the consequence of an accepted pixel
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(pix_valid_i && pix_ready_i, 2))
    else $error("result without a pixel to cause it");

  // results of one pixel follow directly, each one row down or one column right
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !run_last_i |=> res_valid_i
      && (pos_y_i == $past(pos_y_i) + POS_Y_W'(1) || pos_x_i == $past(pos_x_i) + POS_X_W'(1)))
    else $error("results of one pixel out of order");

  a_strength_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> strength_i <= STRENGTH_MAX)
    else $error("strength out of range");

endmodule

bind laplace_edge_strength_filter lesf_checker u_lesf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .pos_x_i     (res_o.pos_x),
  .pos_y_i     (res_o.pos_y),
  .strength_i  (res_o.strength),
  .run_last_i  (res_o.run_last)
);

`default_nettype wire

[sim/laplace_edge_strength_filter_tb.sv]
// ----------------------------------------------------------------------------
// laplace_edge_strength_filter_tb
// Self-checking bench for the four-neighbour Laplace edge-strength filter.
// ----------------------------------------------------------------------------
// Pixels are driven in raster order with bursty valid. The result side stalls
// on its own pattern. A behavioural model of the line store, the counters and
// the registers predicts every result as each pixel transaction is accepted,
// and the checker compares each result transaction in order. Register writes
// only happen once the block has drained. Corner images, tiny and degenerate
// geometries, saturated width, random frames and keep_bits changes are tested.
// ----------------------------------------------------------------------------
`default_nettype none

module laplace_edge_strength_filter_tb;
  import lesf_pkg::*;

  localparam int TIMEOUT       = 4_000_000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 400;

  // index past the end of the register list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [POS_X_W-1:0]    pos_x;
    logic [POS_Y_W-1:0]    pos_y;
    logic [STRENGTH_W-1:0] strength;
    logic                  run_last;
  } strength_res_t;

  typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lesf_pix_if pix_if ();
  lesf_res_if res_if ();

  laplace_edge_strength_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // behavioural copy of the block
  pix_t                row_buf [0:DEPTH-1];
  logic [WIDTH_W-1:0]  img_w_reg;
  logic [HEIGHT_W-1:0] img_h_reg;
  logic [KEEP_W-1:0]   keep_reg;
  int unsigned         col_pos;
  int unsigned         row_pos;
  pix_t                live_pix;
  int unsigned         live_x;
  int unsigned         live_y;
  bit                  live_valid;

  strength_res_t pending_results[$];
  int            err_count;
  int            burst_left;
  int            pixels_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int unsigned eff_width();
    if (img_w_reg == 0) return 1;
    if (img_w_reg > MAX_WIDTH) return MAX_WIDTH;
    return img_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (img_h_reg == 0) ? 1 : img_h_reg;
  endfunction

  function automatic pix_t stored_pixel(input int unsigned x, input int unsigned y);
    if (live_valid && x == live_x && y == live_y) return live_pix;
    return row_buf[(y & 1) * MAX_WIDTH + x];
  endfunction

  function automatic int kept_chan(input pix_t px, input int k);
    return int'(px[8*k +: 8]) >> (8 - int'(keep_reg));
  endfunction

  function automatic int unsigned laplace_at(input int unsigned x, input int unsigned y,
                                             input int unsigned w, input int unsigned h);
    int unsigned total;
    int          sum;
    int          n;
    int          d;
    int          k;
    total = 0;
    for (k = 0; k < 3; k++) begin
      sum = 0;
      n   = 0;
      if (y > 0) begin
        sum += kept_chan(stored_pixel(x, y - 1), k);
        n++;
      end
      if (y + 1 < h) begin
        sum += kept_chan(stored_pixel(x, y + 1), k);
        n++;
      end
      if (x > 0) begin
        sum += kept_chan(stored_pixel(x - 1, y), k);
        n++;
      end
      if (x + 1 < w) begin
        sum += kept_chan(stored_pixel(x + 1, y), k);
        n++;
      end
      d = kept_chan(stored_pixel(x, y), k) * n - sum;
      total += (d < 0) ? -d : d;
    end
    return total;
  endfunction

  function automatic strength_res_t build_result(input int unsigned x, input int unsigned y,
                                                 input int unsigned w, input int unsigned h);
    strength_res_t r;
    r.pos_x    = x[POS_X_W-1:0];
    r.pos_y    = y[POS_Y_W-1:0];
    r.strength = STRENGTH_W'(laplace_at(x, y, w, h));
    r.run_last = 1'b0;
    return r;
  endfunction

  // Works out the results released by one accepted pixel and advances the raster.
  task automatic predict_strengths(input pix_t px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   r;
    int            cnt;
    int            i;
    strength_res_t made [0:2];
    w   = eff_width();
    h   = eff_height();
    c   = (col_pos >= w) ? 0 : col_pos;
    r   = (row_pos >= h) ? 0 : row_pos;
    cnt = 0;
    live_pix   = px;
    live_x     = c;
    live_y     = r;
    live_valid = 1'b1;
    if (r >= 1) begin
      made[cnt] = build_result(c, r - 1, w, h);
      cnt++;
    end
    row_buf[(r & 1) * MAX_WIDTH + c] = px;
    live_valid = 1'b0;
    if (r + 1 == h) begin
      if (c >= 1) begin
        made[cnt] = build_result(c - 1, r, w, h);
        cnt++;
      end
      if (c + 1 == w) begin
        made[cnt] = build_result(c, r, w, h);
        cnt++;
      end
    end
    if (cnt > 0) made[cnt-1].run_last = 1'b1;
    for (i = 0; i < cnt; i++) pending_results.push_back(made[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic pix_t rand_pixel();
    pix_t px;
    int   k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       px[8*k +: 8] = 8'h00;
        1:       px[8*k +: 8] = 8'hFF;
        default: px[8*k +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  // Offers one pixel and returns once the transaction is accepted; valid stays
  // high afterwards, so every caller either sends again or calls quiesce.
  task automatic send_pixel(input pix_t px);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.red   <= px[7:0];
    pix_if.green <= px[15:8];
    pix_if.blue  <= px[23:16];
    do @(posedge clk_i); while (!pix_if.ready);
    predict_strengths(px);
    pixels_sent++;
  endtask

  // Drops valid, waits for every expected result, then lets the pipe empty.
  task automatic quiesce();
    int waited;
    waited = 0;
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w_reg = data[WIDTH_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        img_h_reg = data[HEIGHT_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_KEEP_BITS: keep_reg = data[KEEP_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits beyond each field are junk and must be ignored
  task automatic set_geometry(input int w, input int h, input int keep);
    write_reg(REG_IMAGE_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
    write_reg(REG_KEEP_BITS, {13'($urandom_range(0, 8191)), 3'(keep)});
  endtask

  // result side: stall pattern independent of the sender
  initial begin
    rx_mode_e    mode;
    int          phase_left;
    logic [12:0] pattern;
    res_if.ready = 1'b0;
    phase_left   = 0;
    mode         = RX_OPEN;
    pattern      = '1;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        mode       = rx_mode_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
        pattern    = 13'($urandom) | 13'd1;
      end
      phase_left--;
      case (mode)
        RX_OPEN:    res_if.ready <= 1'b1;
        RX_PATTERN: begin
          res_if.ready <= pattern[0];
          pattern = {pattern[0], pattern[12:1]};
        end
        default:    res_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  initial begin
    strength_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d strength=%0d",
                                    res_if.pos_x, res_if.pos_y, res_if.strength));
        end else begin
          want = pending_results.pop_front();
          if (res_if.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %0d, expected %0d", res_if.pos_x, want.pos_x));
          if (res_if.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %0d, expected %0d", res_if.pos_y, want.pos_y));
          if (res_if.strength !== want.strength)
            report_mismatch($sformatf("strength %0d at (%0d,%0d), expected %0d",
                                      res_if.strength, want.pos_x, want.pos_y,
                                      want.strength));
          if (res_if.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b at (%0d,%0d), expected %0b",
                                      res_if.run_last, want.pos_x, want.pos_y,
                                      want.run_last));
        end
      end
    end
  end

  // corners, max strength, frame wrap, degenerate and tiny geometries
  task automatic test_directed();
    pix_t spot [0:8];
    int   i;
    for (i = 0; i < 9; i++) spot[i] = 24'h000000;
    spot[4] = 24'hFFFFFF;
    set_geometry(3, 3, 7);
    write_reg(REG_SPARE, 16'hFFFF);
    for (i = 0; i < 9; i++) send_pixel(spot[i]);
    // first row of the next frame
    send_pixel(24'hAA55AA);
    send_pixel(24'h55AA55);
    send_pixel(24'h0FF00F);
    quiesce();
    // zero width and height act as a single pixel with no neighbours
    set_geometry(0, 0, 0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h123456);
    quiesce();
    write_reg(REG_KEEP_BITS, 16'd6);
    send_pixel(24'hFFFFFF);
    quiesce();
    set_geometry(1, 3, 5);
    for (i = 0; i < 6; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
    quiesce();
    set_geometry(4, 1, 3);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hC3C3C3);
    send_pixel(24'h3C3C3C);
    quiesce();
  endtask

  task automatic test_random_frames();
    int w;
    int h;
    int area;
    int count;
    int phase;
    int i;
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS - 120) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      set_geometry(w, h, $urandom_range(0, 7));
      area  = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      count = area * $urandom_range(1, 2) + $urandom_range(0, 2 * ((w == 0) ? 1 : w));
      for (i = 0; i < count; i++) begin
        // hold the stream mid-frame until every result is out
        if (phase % 4 == 1 && i == count / 2) quiesce();
        send_pixel(rand_pixel());
      end
      quiesce();
      // new keep_bits without a restart: the frame carries on
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_KEEP_BITS, 16'($urandom_range(0, 7)));
        for (i = 0; i < area; i++) send_pixel(rand_pixel());
        quiesce();
      end
      phase++;
    end
  endtask

  task automatic test_geometry_extremes();
    int i;
    // width beyond the store saturates; start of a single row
    set_geometry(2047, 1, $urandom_range(0, 7));
    for (i = 0; i < 40; i++) send_pixel(rand_pixel());
    quiesce();
    // first row only: no results
    set_geometry(1024, 65535, 4);
    for (i = 0; i < 20; i++) send_pixel(rand_pixel());
    quiesce();
    set_geometry(1, 65535, $urandom_range(1, 7));
    for (i = 0; i < 40; i++) send_pixel(rand_pixel());
    quiesce();
  endtask

  initial begin
    int i;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    err_count    = 0;
    burst_left   = 0;
    pixels_sent  = 0;
    img_w_reg    = WIDTH_RST;
    img_h_reg    = HEIGHT_RST;
    keep_reg     = KEEP_RST;
    col_pos      = 0;
    row_pos      = 0;
    live_valid   = 1'b0;
    for (i = 0; i < DEPTH; i++) row_buf[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_frames();
    test_geometry_extremes();
    quiesce();

    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/lesf_pkg.sv
design/lesf_if.sv
design/lesf_strength.sv
design/laplace_edge_strength_filter.sv
design/lesf_checker.sv
sim/laplace_edge_strength_filter_tb.sv
